[design/plec_pkg.sv]
// Shared types, codes and constants of the positional list engine.
package plec_pkg;

  // Field widths fixed by the transaction format.
  localparam int unsigned DATA_W           = 32;
  localparam int unsigned OP_W             = 3;
  localparam int unsigned POS_IN_W         = 8;
  localparam int unsigned STATUS_W         = 3;
  localparam int unsigned OUT_W            = 5;
  // A display emits at most this many results.
  localparam int unsigned MAX_OUT          = 16;
  localparam int unsigned DEFAULT_CAPACITY = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_DELETE  = 3'd1,
    OP_DISPLAY = 3'd2,
    OP_REVERSE = 3'd3,
    OP_SEARCH  = 3'd4
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_BADPOS  = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_MISSING = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  // Per-cycle command from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE    = 4'd0,
    CMD_LOAD    = 4'd1,
    CMD_REJECT  = 4'd2,
    CMD_UP      = 4'd3,
    CMD_PUT     = 4'd4,
    CMD_DEL_RD  = 4'd5,
    CMD_DOWN    = 4'd6,
    CMD_DEL_END = 4'd7,
    CMD_DISP    = 4'd8,
    CMD_REV_RD  = 4'd9,
    CMD_REV_WA  = 4'd10,
    CMD_REV_WB  = 4'd11,
    CMD_SRCH    = 4'd12
  } cmd_e;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    opcode_e op;
    logic    ins_bad;
    logic    full;
    logic    empty;
    logic    del_bad;
    logic    up_more;
    logic    down_more;
    logic    disp_more;
    logic    scan_more;
    logic    rev_more;
    logic    hit;
    logic    pend;
  } dp_stat_t;

endpackage

[design/plec_ctrl.sv]
// Controller state machine of the positional list engine.
module plec_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  plec_pkg::dp_stat_t stat_i,
  output plec_pkg::cmd_e    cmd_o,
  output logic              busy_o
);
  import plec_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_CHECK   = 12'b0000_0000_0010,
    S_UP      = 12'b0000_0000_0100,
    S_PUT     = 12'b0000_0000_1000,
    S_DEL_RD  = 12'b0000_0001_0000,
    S_DOWN    = 12'b0000_0010_0000,
    S_DEL_END = 12'b0000_0100_0000,
    S_DISP    = 12'b0000_1000_0000,
    S_REV_RD  = 12'b0001_0000_0000,
    S_REV_WA  = 12'b0010_0000_0000,
    S_REV_WB  = 12'b0100_0000_0000,
    S_SRCH    = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   reject;

  // Decide whether the captured transaction fails its checks.
  always_comb begin
    unique case (stat_i.op)
      OP_INSERT:  reject = stat_i.ins_bad | stat_i.full;
      OP_DELETE:  reject = stat_i.empty | stat_i.del_bad;
      OP_DISPLAY: reject = stat_i.empty;
      OP_REVERSE: reject = 1'b0;
      OP_SEARCH:  reject = 1'b0;
      default:    reject = 1'b1;
    endcase
  end

  // Next state and command.
  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (reject) begin
          cmd_o   = CMD_REJECT;
          state_d = S_IDLE;
        end else begin
          unique case (stat_i.op)
            OP_INSERT:  state_d = S_UP;
            OP_DELETE:  state_d = S_DEL_RD;
            OP_DISPLAY: state_d = S_DISP;
            OP_REVERSE: state_d = S_REV_RD;
            OP_SEARCH:  state_d = S_SRCH;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_UP: begin
        cmd_o = CMD_UP;
        if (!stat_i.up_more) state_d = S_PUT;
      end
      S_PUT: begin
        cmd_o   = CMD_PUT;
        state_d = S_IDLE;
      end
      S_DEL_RD: begin
        cmd_o   = CMD_DEL_RD;
        state_d = S_DOWN;
      end
      S_DOWN: begin
        cmd_o = CMD_DOWN;
        if (!stat_i.down_more) state_d = S_DEL_END;
      end
      S_DEL_END: begin
        cmd_o   = CMD_DEL_END;
        state_d = S_IDLE;
      end
      S_DISP: begin
        cmd_o = CMD_DISP;
        if (!stat_i.disp_more) state_d = S_IDLE;
      end
      S_REV_RD: begin
        cmd_o   = CMD_REV_RD;
        state_d = stat_i.rev_more ? S_REV_WA : S_IDLE;
      end
      S_REV_WA: begin
        cmd_o   = CMD_REV_WA;
        state_d = S_REV_WB;
      end
      S_REV_WB: begin
        cmd_o   = CMD_REV_WB;
        state_d = S_REV_RD;
      end
      S_SRCH: begin
        cmd_o = CMD_SRCH;
        if (stat_i.hit || (!stat_i.scan_more && !stat_i.pend)) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

[design/plec_dp.sv]
// Datapath of the positional list engine: element memory, indices and result register.
module plec_dp #(
  parameter int unsigned CAPACITY = plec_pkg::DEFAULT_CAPACITY
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  plec_pkg::cmd_e                      cmd_i,
  input  logic        [plec_pkg::OP_W-1:0]     opcode_i,
  input  logic signed [plec_pkg::DATA_W-1:0]   value_in_i,
  input  logic        [plec_pkg::POS_IN_W-1:0] position_in_i,
  output plec_pkg::dp_stat_t                  stat_o,
  output logic                                valid_o,
  output logic        [plec_pkg::STATUS_W-1:0] status_o,
  output logic signed [plec_pkg::DATA_W-1:0]   value_out_o,
  output logic        [plec_pkg::OUT_W-1:0]    position_out_o,
  output logic        [plec_pkg::OUT_W-1:0]    list_length_o,
  output logic                                last_o
);
  import plec_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Result fields are five bits wide and wrap above 31.
  function automatic logic [OUT_W-1:0] to_out(input logic [CW-1:0] v);
    logic [7:0] w;
    w = 8'(v);
    return w[OUT_W-1:0];
  endfunction

  // Element memory and its registered read ports.
  logic [DATA_W-1:0] mem_q [CAPACITY];
  logic [DATA_W-1:0] rd_a_q, rd_b_q;
  logic              mem_we, rda_en, rdb_en;
  logic [AW-1:0]     mem_waddr, rda_addr, rdb_addr;
  logic [DATA_W-1:0] mem_wdata;

  // Captured transaction and walk state.
  opcode_e             op_q, op_d;
  logic [DATA_W-1:0]   val_q, val_d;
  logic [POS_IN_W-1:0] pos_q, pos_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       ia_q, ia_d, ib_q, ib_d, ea_q, ea_d;
  logic [AW-1:0]       wa_q, wa_d;
  logic                wb_q, wb_d, pend_q, pend_d;

  // Result register.
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [DATA_W-1:0] out_value_q, out_value_d;
  logic [OUT_W-1:0]  out_pos_q, out_pos_d, out_len_q, out_len_d;
  logic              out_last_q, out_last_d;

  // Comparisons shared by the controller flags and the walks.
  logic [8:0]          cnt9, pos9, ia9, ea9, n9;
  logic [CW-1:0]       ia_inc, ia_dec, ea_inc;
  logic [POS_IN_W-1:0] pos_dec;
  status_e             reject_status;

  assign cnt9    = 9'(count_q);
  assign pos9    = {1'b0, pos_q};
  assign ia9     = 9'(ia_q);
  assign ea9     = 9'(ea_q);
  assign n9      = (cnt9 > 9'(MAX_OUT)) ? 9'(MAX_OUT) : cnt9;
  assign ia_inc  = ia_q + CW'(1);
  assign ia_dec  = ia_q - CW'(1);
  assign ea_inc  = ea_q + CW'(1);
  assign pos_dec = pos_q - POS_IN_W'(1);

  assign stat_o.op        = op_q;
  assign stat_o.ins_bad   = (pos_q == '0) || (pos9 > cnt9 + 9'd1);
  assign stat_o.full      = (cnt9 == 9'(CAPACITY));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.del_bad   = (pos_q == '0) || (pos9 > cnt9);
  assign stat_o.up_more   = (ia9 >= pos9);
  assign stat_o.down_more = (ia9 + 9'd1 < cnt9);
  assign stat_o.disp_more = (ia9 < n9);
  assign stat_o.scan_more = (ia_q < count_q);
  assign stat_o.rev_more  = (ia_q < ib_q);
  assign stat_o.hit       = pend_q && (rd_a_q == val_q);
  assign stat_o.pend      = pend_q;

  // Status reported when a transaction fails its checks.
  always_comb begin
    unique case (op_q)
      OP_INSERT:  reject_status = stat_o.ins_bad ? ST_BADPOS : ST_FULL;
      OP_DELETE:  reject_status = stat_o.empty ? ST_EMPTY : ST_BADPOS;
      OP_DISPLAY: reject_status = ST_EMPTY;
      default:    reject_status = ST_BADPOS;
    endcase
  end

  // Command decode: memory accesses, index updates and results.
  always_comb begin
    op_d         = op_q;
    val_d        = val_q;
    pos_d        = pos_q;
    count_d      = count_q;
    ia_d         = ia_q;
    ib_d         = ib_q;
    ea_d         = ea_q;
    wa_d         = wa_q;
    wb_d         = wb_q;
    pend_d       = pend_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    rda_en       = 1'b0;
    rda_addr     = '0;
    rdb_en       = 1'b0;
    rdb_addr     = '0;
    out_valid_d  = 1'b0;
    out_status_d = ST_OK;
    out_value_d  = '0;
    out_pos_d    = '0;
    out_len_d    = to_out(count_q);
    out_last_d   = 1'b1;
    unique case (cmd_i)
      CMD_LOAD: begin
        op_d   = opcode_e'(opcode_i);
        val_d  = value_in_i;
        pos_d  = position_in_i;
        wb_d   = 1'b0;
        pend_d = 1'b0;
        if (opcode_i == OP_DELETE) begin
          ia_d = CW'(position_in_i - POS_IN_W'(1));
        end else if (opcode_i == OP_INSERT) begin
          ia_d = count_q;
        end else begin
          ia_d = '0;
        end
        ib_d = (count_q == '0) ? '0 : count_q - CW'(1);
      end
      CMD_REJECT: begin
        out_valid_d  = 1'b1;
        out_status_d = reject_status;
      end
      CMD_UP: begin
        // Move entries one place up, from the tail down to the insert point.
        if (wb_q) begin
          mem_we    = 1'b1;
          mem_waddr = wa_q;
          mem_wdata = rd_a_q;
        end
        if (stat_o.up_more) begin
          rda_en   = 1'b1;
          rda_addr = ia_dec[AW-1:0];
          wa_d     = ia_q[AW-1:0];
          wb_d     = 1'b1;
          ia_d     = ia_dec;
        end else begin
          wb_d = 1'b0;
        end
      end
      CMD_PUT: begin
        mem_we       = 1'b1;
        mem_waddr    = pos_dec[AW-1:0];
        mem_wdata    = val_q;
        count_d      = count_q + CW'(1);
        out_valid_d  = 1'b1;
        out_pos_d    = pos_q[OUT_W-1:0];
        out_len_d    = to_out(count_q + CW'(1));
      end
      CMD_DEL_RD: begin
        rdb_en   = 1'b1;
        rdb_addr = ia_q[AW-1:0];
      end
      CMD_DOWN: begin
        // Move entries one place down, from the delete point to the tail.
        if (wb_q) begin
          mem_we    = 1'b1;
          mem_waddr = wa_q;
          mem_wdata = rd_a_q;
        end
        if (stat_o.down_more) begin
          rda_en   = 1'b1;
          rda_addr = ia_inc[AW-1:0];
          wa_d     = ia_q[AW-1:0];
          wb_d     = 1'b1;
          ia_d     = ia_inc;
        end else begin
          wb_d = 1'b0;
        end
      end
      CMD_DEL_END: begin
        count_d     = count_q - CW'(1);
        out_valid_d = 1'b1;
        out_value_d = rd_b_q;
        out_len_d   = to_out(count_q - CW'(1));
      end
      CMD_DISP: begin
        if (pend_q) begin
          out_valid_d = 1'b1;
          out_value_d = rd_a_q;
          out_pos_d   = to_out(ea_inc);
          out_last_d  = (ea9 + 9'd1 == n9);
        end
        if (stat_o.disp_more) begin
          rda_en   = 1'b1;
          rda_addr = ia_q[AW-1:0];
          pend_d   = 1'b1;
          ea_d     = ia_q;
          ia_d     = ia_inc;
        end else begin
          pend_d = 1'b0;
        end
      end
      CMD_REV_RD: begin
        if (stat_o.rev_more) begin
          rda_en   = 1'b1;
          rda_addr = ia_q[AW-1:0];
          rdb_en   = 1'b1;
          rdb_addr = ib_q[AW-1:0];
        end else begin
          out_valid_d = 1'b1;
        end
      end
      CMD_REV_WA: begin
        mem_we    = 1'b1;
        mem_waddr = ia_q[AW-1:0];
        mem_wdata = rd_b_q;
      end
      CMD_REV_WB: begin
        mem_we    = 1'b1;
        mem_waddr = ib_q[AW-1:0];
        mem_wdata = rd_a_q;
        ia_d      = ia_inc;
        ib_d      = ib_q - CW'(1);
      end
      CMD_SRCH: begin
        // Compare each read in the cycle after it is issued.
        if (stat_o.hit) begin
          out_valid_d = 1'b1;
          out_value_d = val_q;
          out_pos_d   = to_out(ea_inc);
        end else if (stat_o.scan_more) begin
          rda_en   = 1'b1;
          rda_addr = ia_q[AW-1:0];
          pend_d   = 1'b1;
          ea_d     = ia_q;
          ia_d     = ia_inc;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          out_valid_d  = 1'b1;
          out_status_d = ST_MISSING;
        end
      end
      default: begin
      end
    endcase
  end

  // Element memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (rda_en) rd_a_q <= mem_q[rda_addr];
    if (rdb_en) rd_b_q <= mem_q[rdb_addr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      wb_q        <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      wb_q        <= wb_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    val_q        <= val_d;
    pos_q        <= pos_d;
    ia_q         <= ia_d;
    ib_q         <= ib_d;
    ea_q         <= ea_d;
    wa_q         <= wa_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_pos_q    <= out_pos_d;
    out_len_q    <= out_len_d;
    out_last_q   <= out_last_d;
  end

  assign valid_o        = out_valid_q;
  assign status_o       = out_status_q;
  assign value_out_o    = out_value_q;
  assign position_out_o = out_pos_q;
  assign list_length_o  = out_len_q;
  assign last_o         = out_last_q;

endmodule

[design/positional_list_engine_core.sv]
// Top level of the positional list engine: controller, datapath and checks.
//
//  Channel   Handshake          Payload
//  --------  -----------------  ----------------------------------------------------
//  command   start, busy        opcode_i, value_in_i, position_in_i
//  result    valid_o (strobe)   status_o, value_out_o, position_out_o,
//                               list_length_o, last_o
//
// A transaction is taken when start is high and busy is low; busy falls as the final result
// is registered. An insert moves entries up one place from the tail, then writes the value;
// a delete reads the entry, then moves the entries above it down; display and search read
// entries from the head; reverse swaps pairs from both ends, reading a pair, then writing both.
// The single write port of the element memory moves one entry per cycle during a shift.
// Reset clears the element count and the controller; the receiver cannot stall a result.
module positional_list_engine_core #(
  parameter int unsigned CAPACITY = plec_pkg::DEFAULT_CAPACITY
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  input  logic        [plec_pkg::OP_W-1:0]     opcode_i,
  input  logic signed [plec_pkg::DATA_W-1:0]   value_in_i,
  input  logic        [plec_pkg::POS_IN_W-1:0] position_in_i,
  output logic                                busy,
  output logic                                valid_o,
  output logic        [plec_pkg::STATUS_W-1:0] status_o,
  output logic signed [plec_pkg::DATA_W-1:0]   value_out_o,
  output logic        [plec_pkg::OUT_W-1:0]    position_out_o,
  output logic        [plec_pkg::OUT_W-1:0]    list_length_o,
  output logic                                last_o
);
  import plec_pkg::*;

  cmd_e     cmd;
  dp_stat_t stat;

  // Sequencer.
  plec_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Element store and result generation.
  plec_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .opcode_i       (opcode_i),
    .value_in_i     (value_in_i),
    .position_in_i  (position_in_i),
    .stat_o         (stat),
    .valid_o        (valid_o),
    .status_o       (status_o),
    .value_out_o    (value_out_o),
    .position_out_o (position_out_o),
    .list_length_o  (list_length_o),
    .last_o         (last_o)
  );

  // An accepted transaction takes the controller out of idle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transaction did not make the block busy");

  // The datapath captures a transaction only while the controller is idle.
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == CMD_LOAD) |-> !busy)
    else $error("transaction captured while busy");

  // A result that is not the final one leaves more work in progress.
  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> busy)
    else $error("non-final result with the block idle");

  // The reported length never exceeds the capacity where it cannot wrap.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (CAPACITY > 31) || (int'(list_length_o) <= CAPACITY))
    else $error("list length above capacity");

endmodule

[tb/positional_list_engine_core_tb.sv]
// Self-checking testbench of the positional list engine core with its own list predictor.
module positional_list_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plec_pkg::*;

  localparam int unsigned LIST_CAP      = DEFAULT_CAPACITY;
  localparam int unsigned RANDOM_ITEMS  = 110;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 64;

  // One command transaction waiting to be driven.
  typedef struct {
    logic [OP_W-1:0]            op;
    logic signed [DATA_W-1:0]   value;
    logic [POS_IN_W-1:0]        pos;
    int unsigned                gap;
    bit                         drain;
  } list_cmd_t;

  // One result transaction as the block should present it.
  typedef struct {
    logic [STATUS_W-1:0]        status;
    logic signed [DATA_W-1:0]   value;
    logic [OUT_W-1:0]           position;
    logic [OUT_W-1:0]           length;
    logic                       last;
  } list_result_t;

  logic                         clk_i;
  logic                         rst_ni        = 1'b0;
  logic                         start         = 1'b0;
  logic [OP_W-1:0]              opcode_i      = '0;
  logic signed [DATA_W-1:0]     value_in_i    = '0;
  logic [POS_IN_W-1:0]          position_in_i = '0;
  logic                         busy;
  logic                         valid_o;
  logic [STATUS_W-1:0]          status_o;
  logic signed [DATA_W-1:0]     value_out_o;
  logic [OUT_W-1:0]             position_out_o;
  logic [OUT_W-1:0]             list_length_o;
  logic                         last_o;

  list_cmd_t                    cmd_queue[$];
  list_result_t                 expected_results[$];
  logic signed [DATA_W-1:0]     value_pool[$];

  // Predicted list contents and length.
  logic signed [DATA_W-1:0]     model_vals[LIST_CAP];
  int unsigned                  model_len     = 0;

  // Length the stimulus generator believes the list has.
  int unsigned                  gen_len       = 0;
  bit                           no_idle       = 1'b0;

  int unsigned                  accepted      = 0;
  int unsigned                  total_cmds    = 0;
  int unsigned                  gap_left      = 0;
  int unsigned                  mismatches    = 0;
  int unsigned                  cycle_count   = 0;

  positional_list_engine_core #(
    .CAPACITY(LIST_CAP)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .opcode_i      (opcode_i),
    .value_in_i    (value_in_i),
    .position_in_i (position_in_i),
    .busy          (busy),
    .valid_o       (valid_o),
    .status_o      (status_o),
    .value_out_o   (value_out_o),
    .position_out_o(position_out_o),
    .list_length_o (list_length_o),
    .last_o        (last_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Prints a single line per mismatch and counts it.
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Queues one expected result; the length reflects the list after the operation.
  function automatic void expect_result(input status_e st, input logic signed [DATA_W-1:0] v,
                                        input int unsigned p, input logic fin);
    list_result_t r;
    r.status   = st;
    r.value    = v;
    r.position = p[OUT_W-1:0];
    r.length   = model_len[OUT_W-1:0];
    r.last     = fin;
    expected_results.push_back(r);
  endfunction

  // Applies one accepted command to the predicted list and queues its results.
  function automatic void predict_list_op(input logic [OP_W-1:0] op,
                                          input logic signed [DATA_W-1:0] val,
                                          input logic [POS_IN_W-1:0] pos);
    int unsigned              p;
    int unsigned              n;
    int                       i;
    logic signed [DATA_W-1:0] tmp;
    bit                       hit;
    p   = pos;
    hit = 1'b0;
    case (op)
      OP_INSERT: begin
        // Position is checked before capacity.
        if (p < 1 || p > model_len + 1) begin
          expect_result(ST_BADPOS, '0, 0, 1'b1);
        end else if (model_len >= LIST_CAP) begin
          expect_result(ST_FULL, '0, 0, 1'b1);
        end else begin
          for (i = model_len; i >= int'(p); i--) model_vals[i] = model_vals[i-1];
          model_vals[p-1] = val;
          model_len++;
          expect_result(ST_OK, '0, p, 1'b1);
        end
      end
      OP_DELETE: begin
        if (model_len == 0) begin
          expect_result(ST_EMPTY, '0, 0, 1'b1);
        end else if (p < 1 || p > model_len) begin
          expect_result(ST_BADPOS, '0, 0, 1'b1);
        end else begin
          tmp = model_vals[p-1];
          for (i = p - 1; i + 1 < int'(model_len); i++) model_vals[i] = model_vals[i+1];
          model_len--;
          expect_result(ST_OK, tmp, 0, 1'b1);
        end
      end
      OP_DISPLAY: begin
        n = (model_len < MAX_OUT) ? model_len : MAX_OUT;
        if (n == 0) begin
          expect_result(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          for (i = 0; i < int'(n); i++) begin
            expect_result(ST_OK, model_vals[i], i + 1, (i + 1 == int'(n)));
          end
        end
      end
      OP_REVERSE: begin
        for (i = 0; i < int'(model_len / 2); i++) begin
          tmp                        = model_vals[i];
          model_vals[i]              = model_vals[model_len-1-i];
          model_vals[model_len-1-i]  = tmp;
        end
        expect_result(ST_OK, '0, 0, 1'b1);
      end
      OP_SEARCH: begin
        // First matching position wins.
        for (i = 0; i < int'(model_len); i++) begin
          if (!hit && model_vals[i] == val) begin
            hit = 1'b1;
            expect_result(ST_OK, val, i + 1, 1'b1);
          end
        end
        if (!hit) expect_result(ST_MISSING, '0, 0, 1'b1);
      end
      default: begin
        // Unknown opcodes leave the list alone and report a bad position.
        expect_result(ST_BADPOS, '0, 0, 1'b1);
      end
    endcase
  endfunction

  // Picks a data value, with the extremes appearing now and then.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Appends a command, chooses its idle gap and tracks the list length it leads to.
  task automatic queue_cmd(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val,
                           input logic [POS_IN_W-1:0] pos, input bit drain);
    list_cmd_t   c;
    int unsigned p;
    int unsigned roll;
    c.op    = op;
    c.value = val;
    c.pos   = pos;
    c.drain = drain;
    roll    = $urandom_range(0, 99);
    if (no_idle || roll < 55) c.gap = 0;
    else if (roll < 88)       c.gap = $urandom_range(1, 3);
    else if (roll < 97)       c.gap = $urandom_range(4, 12);
    else                      c.gap = $urandom_range(20, 60);
    p = pos;
    if (op == OP_INSERT && p >= 1 && p <= gen_len + 1 && gen_len < LIST_CAP) begin
      gen_len++;
      value_pool.push_back(val);
      if (value_pool.size() > 24) void'(value_pool.pop_front());
    end else if (op == OP_DELETE && gen_len > 0 && p >= 1 && p <= gen_len) begin
      gen_len--;
    end
    cmd_queue.push_back(c);
  endtask

  // Driver: presents queued commands, honouring gaps and drain requests.
  always @(posedge clk_i) begin
    bit        fire;
    bit        launch;
    list_cmd_t nxt;
    if (rst_ni) begin
      fire = (start === 1'b1) && (busy === 1'b0);
      if (fire) begin
        predict_list_op(opcode_i, value_in_i, position_in_i);
        accepted++;
        if (cmd_queue.size() != 0) gap_left = cmd_queue[0].gap;
      end
      launch = (fire || !start) && cmd_queue.size() != 0 && gap_left == 0 &&
               !(cmd_queue[0].drain && expected_results.size() != 0);
      if (launch) begin
        nxt            = cmd_queue.pop_front();
        start         <= 1'b1;
        opcode_i      <= nxt.op;
        value_in_i    <= nxt.value;
        position_in_i <= nxt.pos;
      end else if (fire) begin
        start <= 1'b0;
      end else if (!start && gap_left > 0) begin
        gap_left--;
      end
    end
  end

  // Monitor: compares every strobed result with the oldest expectation.
  always @(posedge clk_i) begin
    list_result_t exp_r;
    if (rst_ni && valid_o !== 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result strobe with no transaction outstanding");
      end else begin
        exp_r = expected_results.pop_front();
        if (status_o !== exp_r.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, exp_r.status));
        if (value_out_o !== exp_r.value)
          report_mismatch($sformatf("value_out %0d, expected %0d", value_out_o, exp_r.value));
        if (position_out_o !== exp_r.position)
          report_mismatch($sformatf("position_out %0d, expected %0d",
                                    position_out_o, exp_r.position));
        if (list_length_o !== exp_r.length)
          report_mismatch($sformatf("list_length %0d, expected %0d",
                                    list_length_o, exp_r.length));
        if (last_o !== exp_r.last)
          report_mismatch($sformatf("last %0b, expected %0b", last_o, exp_r.last));
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus generation, reset and end of run.
  initial begin
    int unsigned k;
    int unsigned roll;
    logic [POS_IN_W-1:0] p;

    // Directed opening: empty-list cases, bounds, extremes and unknown opcodes.
    queue_cmd(OP_DISPLAY, pick_value(), 8'd0, 1'b0);
    queue_cmd(OP_DELETE,  pick_value(), 8'd1, 1'b0);
    queue_cmd(OP_SEARCH,  32'sd0,       8'd0, 1'b0);
    queue_cmd(OP_REVERSE, pick_value(), 8'hFF, 1'b0);
    queue_cmd(OP_INSERT,  32'sd5,       8'd0, 1'b0);
    queue_cmd(OP_INSERT,  32'sd6,       8'd2, 1'b0);
    queue_cmd(OP_INSERT,  32'sh7FFF_FFFF, 8'd1, 1'b0);
    queue_cmd(OP_INSERT,  32'sh8000_0000, 8'd1, 1'b0);
    queue_cmd(OP_INSERT,  -32'sd1,      8'd3, 1'b0);
    queue_cmd(OP_INSERT,  32'sd7,       8'hFF, 1'b0);
    queue_cmd(OP_SEARCH,  32'sh8000_0000, 8'hAA, 1'b0);
    queue_cmd(OP_SEARCH,  32'sd12345,   8'h55, 1'b0);
    queue_cmd(OP_REVERSE, 32'sd0,       8'd0, 1'b0);
    queue_cmd(OP_DISPLAY, 32'sd0,       8'd0, 1'b0);
    queue_cmd(OP_DELETE,  32'sd0,       8'd4, 1'b0);
    queue_cmd(OP_DELETE,  32'sd0,       8'd0, 1'b0);
    queue_cmd(OP_DELETE,  32'sd0,       8'd2, 1'b0);
    queue_cmd(OP_REVERSE, 32'sd0,       8'd0, 1'b0);
    queue_cmd(OP_DISPLAY, 32'sd0,       8'd0, 1'b0);
    queue_cmd(3'd5, $urandom, 8'hFF, 1'b0);
    queue_cmd(3'd6, $urandom, 8'd1,  1'b0);
    queue_cmd(3'd7, $urandom, 8'd0,  1'b1);

    // Random part: mostly legal operations, with bad positions and junk opcodes mixed in.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      no_idle = ((k / 30) % 3 == 1);
      if (k == 40) begin
        // Fill to capacity, then hit the full store and show the whole list.
        while (gen_len < LIST_CAP) begin
          queue_cmd(OP_INSERT, pick_value(), POS_IN_W'($urandom_range(1, gen_len + 1)), 1'b0);
        end
        queue_cmd(OP_INSERT, pick_value(), POS_IN_W'($urandom_range(1, LIST_CAP + 1)), 1'b0);
        queue_cmd(OP_INSERT, pick_value(), POS_IN_W'(LIST_CAP + 1), 1'b0);
        queue_cmd(OP_INSERT, pick_value(), POS_IN_W'(LIST_CAP + 2), 1'b0);
        queue_cmd(OP_DISPLAY, pick_value(), POS_IN_W'($urandom_range(0, 255)), 1'b1);
        queue_cmd(OP_REVERSE, pick_value(), POS_IN_W'($urandom_range(0, 255)), 1'b0);
        queue_cmd(OP_DISPLAY, pick_value(), POS_IN_W'($urandom_range(0, 255)), 1'b0);
      end else if (k == 100) begin
        // Empty the list completely, then probe the empty cases again.
        while (gen_len > 0) begin
          queue_cmd(OP_DELETE, pick_value(), POS_IN_W'($urandom_range(1, gen_len)), 1'b0);
        end
        queue_cmd(OP_DISPLAY, pick_value(), POS_IN_W'($urandom_range(0, 255)), 1'b0);
        queue_cmd(OP_DELETE,  pick_value(), POS_IN_W'($urandom_range(0, 255)), 1'b0);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 34) begin
          queue_cmd(OP_INSERT, pick_value(), POS_IN_W'($urandom_range(1, gen_len + 1)),
                    ($urandom_range(0, 99) < 3));
        end else if (roll < 54) begin
          p = (gen_len > 0) ? POS_IN_W'($urandom_range(1, gen_len)) :
                              POS_IN_W'($urandom_range(0, 255));
          queue_cmd(OP_DELETE, pick_value(), p, ($urandom_range(0, 99) < 3));
        end else if (roll < 64) begin
          queue_cmd(OP_SEARCH,
                    (value_pool.size() != 0) ?
                      value_pool[$urandom_range(0, value_pool.size() - 1)] : pick_value(),
                    POS_IN_W'($urandom_range(0, 255)), 1'b0);
        end else if (roll < 69) begin
          queue_cmd(OP_SEARCH, pick_value(), POS_IN_W'($urandom_range(0, 255)), 1'b0);
        end else if (roll < 77) begin
          queue_cmd(OP_DISPLAY, pick_value(), POS_IN_W'($urandom_range(0, 255)),
                    ($urandom_range(0, 99) < 3));
        end else if (roll < 84) begin
          queue_cmd(OP_REVERSE, pick_value(), POS_IN_W'($urandom_range(0, 255)), 1'b0);
        end else if (roll < 91) begin
          p = ($urandom_range(0, 3) == 0) ? 8'd0 :
                                            POS_IN_W'($urandom_range(gen_len + 2, 255));
          queue_cmd(OP_INSERT, pick_value(), p, 1'b0);
        end else if (roll < 96) begin
          p = ($urandom_range(0, 3) == 0) ? 8'd0 :
                                            POS_IN_W'($urandom_range(gen_len + 1, 255));
          queue_cmd(OP_DELETE, pick_value(), p, 1'b0);
        end else begin
          queue_cmd(OP_W'($urandom_range(5, 7)), $urandom,
                    POS_IN_W'($urandom_range(0, 255)), 1'b0);
        end
      end
    end
    total_cmds = cmd_queue.size();

    // Reset once at the start of the run.
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every transaction to be taken and answered, then let the block settle.
    while (accepted < total_cmds || expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", expected_results.size()));
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
